[rtl/svt_pkg.sv]
// shared types and constants for the sorted value table
package svt_pkg;

	localparam int CAPACITY = 32;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int VAL_W    = 32;

	typedef logic signed [VAL_W-1:0] value_t;
	typedef logic [IDX_W-1:0]        index_t;
	typedef logic [CNT_W-1:0]        count_t;

	typedef enum logic [1:0] {
		MODE_INSERT = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_FIND   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2
	} status_t;

	// broadcast from the controller to every cell
	typedef struct packed {
		logic   do_ins;
		logic   do_rem;
		logic   hit;
		value_t key;
	} cell_ctrl_t;

endpackage

[rtl/svt_ifs.sv]
// request and result channel interfaces
interface svt_req_if import svt_pkg::*;;
	logic   valid;
	logic   ready;
	mode_t  mode;
	value_t value;

	modport source (output valid, output mode, output value, input ready);
	modport sink (input valid, input mode, input value, output ready);
endinterface

interface svt_res_if import svt_pkg::*;;
	logic    valid;
	logic    ready;
	status_t status;
	index_t  position;
	count_t  count;
	logic    empty_res;

	modport source (output valid, output status, output position, output count,
		output empty_res, input ready);
	modport sink (input valid, input status, input position, input count,
		input empty_res, output ready);
endinterface

[rtl/svt_cell.sv]
// one table slot: holds an entry, compares it with the key, shifts with its neighbors
module svt_cell import svt_pkg::*; (
	input  logic       clk,
	input  cell_ctrl_t ctrl,
	input  logic       occ,
	input  logic       left_lt,
	input  value_t     left_entry,
	input  value_t     right_entry,
	output value_t     entry,
	output logic       lt,
	output logic       eq
);

	value_t entry_q;

	assign lt    = occ && (entry_q < ctrl.key);
	assign eq    = occ && (entry_q == ctrl.key);
	assign entry = entry_q;

	always_ff @(posedge clk) begin
		if (ctrl.do_ins && !lt) begin
			// first slot not below the key takes it, the rest move up
			if (left_lt) begin
				entry_q <= ctrl.key;
			end else begin
				entry_q <= left_entry;
			end
		end else if (ctrl.do_rem && ctrl.hit && !lt) begin
			entry_q <= right_entry;
		end
	end

endmodule

[rtl/sorted_value_table.sv]
// sorted value table top level: request register, cell chain and result register
// a request is held in the request stage, then its result is loaded into the result register
// throughput: one transaction per cycle while the result side keeps up
// the whole chain compares while the request is in the request stage and shifts as it advances
// reset clears entry count and handshake state; entries themselves are not cleared
module sorted_value_table import svt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	svt_req_if.sink   req,
	svt_res_if.source res
);

	// request stage
	logic   valid_s1;
	mode_t  mode_s1;
	value_t value_s1;

	// table state
	count_t count_q;

	// result register
	logic    res_valid_q;
	status_t res_status_q;
	index_t  res_position_q;
	count_t  res_count_q;
	logic    res_empty_q;

	// chain wiring
	cell_ctrl_t            ctrl;
	logic [CAPACITY-1:0]   occ;
	logic [CAPACITY-1:0]   lt_vec;
	logic [CAPACITY-1:0]   eq_vec;
	logic [CAPACITY-1:0]   left_lt;
	logic [CAPACITY-1:0]   first_hit;
	value_t                entry_vec [CAPACITY];

	logic    advance;
	logic    full;
	logic    hit;
	index_t  hit_pos;
	count_t  count_d;
	status_t status_d;
	index_t  position_d;

	// the request stage moves on once the result register is free
	assign advance   = valid_s1 && (!res_valid_q || res.ready);
	assign req.ready = !valid_s1 || advance;

	assign full = (count_q == CNT_W'(CAPACITY));
	assign hit  = |eq_vec;

	assign ctrl.do_ins = advance && (mode_s1 == MODE_INSERT) && !full;
	assign ctrl.do_rem = advance && (mode_s1 == MODE_REMOVE);
	assign ctrl.hit    = hit;
	assign ctrl.key    = value_s1;

	// the cell chain; slot 0 sees an always-less left neighbor
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		assign occ[i] = (CNT_W'(i) < count_q);

		if (i == 0) begin : g_head
			assign left_lt[i] = 1'b1;
		end else begin : g_body
			assign left_lt[i] = lt_vec[i-1];
		end

		svt_cell u_cell (
			.clk         (clk),
			.ctrl        (ctrl),
			.occ         (occ[i]),
			.left_lt     (left_lt[i]),
			.left_entry  ((i == 0) ? value_s1 : entry_vec[(i == 0) ? 0 : i-1]),
			.right_entry ((i == CAPACITY-1) ? value_s1
				: entry_vec[(i == CAPACITY-1) ? i : i+1]),
			.entry       (entry_vec[i]),
			.lt          (lt_vec[i]),
			.eq          (eq_vec[i])
		);
	end

	// first equal slot is the one whose left neighbor is still below the key
	assign first_hit = eq_vec & left_lt;

	always_comb begin
		hit_pos = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (first_hit[i]) begin
				hit_pos = hit_pos | IDX_W'(i);
			end
		end
	end

	// status, position and new count for the request in the stage
	always_comb begin
		count_d    = count_q;
		status_d   = ST_OK;
		position_d = '0;
		case (mode_s1)
			MODE_INSERT: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
				end
			end
			MODE_REMOVE: begin
				if (hit) begin
					count_d = count_q - CNT_W'(1);
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			MODE_FIND: begin
				if (hit) begin
					position_d = hit_pos;
				end else begin
					status_d = ST_NOT_FOUND;
				end
			end
			MODE_CLEAR: begin
				count_d = '0;
			end
			default: begin
				count_d = count_q;
			end
		endcase
	end

	// request stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			mode_s1  <= req.mode;
			value_s1 <= req.value;
		end
	end

	// entry count and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (advance) begin
				count_q     <= count_d;
				res_valid_q <= 1'b1;
			end else if (res.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_status_q   <= status_d;
			res_position_q <= position_d;
			res_count_q    <= count_d;
			res_empty_q    <= (count_d == '0);
		end
	end

	assign res.valid     = res_valid_q;
	assign res.status    = res_status_q;
	assign res.position  = res_position_q;
	assign res.count     = res_count_q;
	assign res.empty_res = res_empty_q;

	// checks on the table logic
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CAPACITY))
		else $error("entry count above capacity");

	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(first_hit))
		else $error("more than one first match");

	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		((lt_vec >> 1) & ~lt_vec) == '0)
		else $error("less-than flags are not a prefix");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (mode_s1 == MODE_CLEAR) |=> (count_q == '0) && res_empty_q)
		else $error("clear left entries behind");

	a_stage_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(value_s1))
		else $error("pending request lost");

endmodule
